// ===== rtl/core/clz_pkg.sv =====
// ============================================================================
// clz_pkg
// Shared widths, limits and types for the range max cycle length core.
// ============================================================================
package clz_pkg;

    localparam int LEN_W = 10;                  // reported cycle length width
    localparam int CNT_W = 11;                  // internal count, saturating
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(1023);
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    localparam int OUT_W = ((LEN_W + 1 + 7) / 8) * 8;

    // status of one trajectory step
    typedef struct packed {
        logic at_end;   // value is 1 or less
        logic odd;      // value is odd, 3n+1 path
        logic ovf;      // 3n+1 does not fit the trajectory register
    } clz_step_flags_t;

endpackage

// ===== rtl/core/clz_step_unit.sv =====
// ============================================================================
// clz_step_unit
// Shared trajectory step: halve if even, else 3n+1 with overflow detect.
// ============================================================================
module clz_step_unit
    import clz_pkg::*;
#(
    parameter int TRAJ_BITS = 64
)
(
    input  logic [TRAJ_BITS-1:0] value,
    output logic [TRAJ_BITS-1:0] next_value,
    output clz_step_flags_t      flags
);

    logic [TRAJ_BITS+1:0] triple_sum;

    // 3n+1 as n + 2n + 1; carry out of TRAJ_BITS flags overflow
    assign triple_sum = {2'b00, value} + {1'b0, value, 1'b0} + (TRAJ_BITS+2)'(1);

    assign flags.odd    = value[0];
    assign flags.ovf    = value[0] & (|triple_sum[TRAJ_BITS+1:TRAJ_BITS]);
    assign flags.at_end = (value[TRAJ_BITS-1:1] == '0);

    assign next_value = value[0] ? triple_sum[TRAJ_BITS-1:0] : (value >> 1);

endmodule

// ===== rtl/core/clz_memo.sv =====
// ============================================================================
// clz_memo
// Cycle length memo: single-port memory with a clearing sweep after reset.
// ============================================================================
module clz_memo
    import clz_pkg::*;
#(
    parameter int ENTRIES = 32768,
    parameter int AW      = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [LEN_W-1:0] wdata,
    output logic [LEN_W-1:0] rdata,
    output logic             busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    logic [LEN_W-1:0] mem [ENTRIES];

    logic          clr_reg;
    logic          clr_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [LEN_W-1:0] mem_wdata;

    assign busy = clr_reg;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we    = clr_reg | wr_en;
    assign mem_waddr = clr_reg ? clr_addr_reg : addr;
    assign mem_wdata = clr_reg ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/core/collatz_range_max_length_core.sv =====
// ============================================================================
// collatz_range_max_length_core
// Largest 3n+1 cycle length over an inclusive range of start values.
// ============================================================================
// Usage:
//   s_axis carries one item: two range bounds in either order. m_axis returns
//   one item per input: the largest cycle length in the range (saturated at
//   1023) and an overflow flag set when some trajectory outgrew TRAJ_BITS.
//   A single step unit advances the trajectory under a small sequencer; the
//   item is walked start by start, each trajectory value taking a test state
//   (which may issue the memo lookup), then a memo or step state. Each start
//   passes a start state, those pairs and a finish state; a memoized length
//   or an overflow can end the walk early. After the last start a done state
//   loads the result register. s_axis_tready is high only while the core is
//   idle. The result sits in an output register; once it is loaded the core
//   goes idle and accepts the next item. If the receiver stalls, the core
//   holds the next finished result in its done state until the output is taken.
//   After reset the memo is swept to zero, one entry per cycle (a single
//   entry if MEMO_DEPTH is 0 or 1); then the first item can be accepted.
// ============================================================================
module collatz_range_max_length_core
    import clz_pkg::*;
#(
    parameter int START_BITS = 20,
    parameter int TRAJ_BITS  = 64,
    parameter int MEMO_DEPTH = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [START_BITS-1:0] bound_a, [2*START_BITS-1:START_BITS] bound_b, zero pad
    input  logic [((2 * START_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [9:0] max_length, [10] overflow, zero pad
    output logic [OUT_W-1:0]    m_axis_tdata
);

    localparam int MEMO_ENTRIES = (MEMO_DEPTH > 1) ? MEMO_DEPTH : 1;
    localparam int MEMO_AW     = (MEMO_DEPTH > 1) ? $clog2(MEMO_DEPTH) : 1;
    localparam logic [TRAJ_BITS-1:0] MEMO_LIM = TRAJ_BITS'(MEMO_DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_MEMO   = 3'd4;
    localparam logic [2:0] ST_STEP   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]            state_reg,   state_next;
    logic [START_BITS-1:0] s_reg,       s_next;
    logic [START_BITS-1:0] hi_reg,      hi_next;
    logic [TRAJ_BITS-1:0]  v_reg,       v_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic [LEN_W-1:0]      max_reg,     max_next;
    logic                  ovf_reg,     ovf_next;
    logic                  tovf_reg,    tovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [START_BITS-1:0] bound_a;
    logic [START_BITS-1:0] bound_b;
    logic                  in_accept;

    logic [TRAJ_BITS-1:0]  step_value;
    clz_step_flags_t       step_flags;

    logic                  memo_rd_en;
    logic                  memo_wr_en;
    logic [MEMO_AW-1:0]    memo_addr;
    logic [LEN_W-1:0]      memo_rdata;
    logic                  memo_busy;

    logic [TRAJ_BITS-1:0]  s_ext;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W:0]        memo_sum;
    logic [CNT_W-1:0]      cnt_memo;
    logic [LEN_W-1:0]      len_sat;

    assign bound_a = s_axis_tdata[START_BITS-1:0];
    assign bound_b = s_axis_tdata[2*START_BITS-1:START_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W-LEN_W-1)'(0), out_ovf_reg, out_len_reg};

    clz_step_unit #(
        .TRAJ_BITS (TRAJ_BITS)
    ) u_step (
        .value      (v_reg),
        .next_value (step_value),
        .flags      (step_flags)
    );

    clz_memo #(
        .ENTRIES (MEMO_ENTRIES),
        .AW      (MEMO_AW)
    ) u_memo (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (memo_rd_en),
        .wr_en (memo_wr_en),
        .addr  (memo_addr),
        .wdata (len_sat),
        .rdata (memo_rdata),
        .busy  (memo_busy)
    );

    assign s_ext    = TRAJ_BITS'(s_reg);
    assign cnt_inc  = (cnt_reg == CNT_SAT) ? cnt_reg : cnt_reg + CNT_W'(1);
    // known length of the memo value, minus the value itself already counted
    assign memo_sum = {1'b0, cnt_reg} + (CNT_W+1)'(memo_rdata) - (CNT_W+1)'(1);
    assign cnt_memo = memo_sum[CNT_W] ? CNT_SAT : memo_sum[CNT_W-1:0];
    assign len_sat  = (cnt_reg > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : cnt_reg[LEN_W-1:0];

    assign memo_rd_en = (state_reg == ST_TEST) & ~step_flags.at_end & (v_reg < MEMO_LIM);
    assign memo_wr_en = (state_reg == ST_FINISH) & ~tovf_reg & (cnt_reg <= LEN_MAX)
                        & (s_ext < MEMO_LIM);
    assign memo_addr  = (state_reg == ST_FINISH) ? s_ext[MEMO_AW-1:0] : v_reg[MEMO_AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        hi_next        = hi_reg;
        v_next         = v_reg;
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        ovf_next       = ovf_reg;
        tovf_next      = tovf_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!memo_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    s_next     = (bound_a < bound_b) ? bound_a : bound_b;
                    hi_next    = (bound_a < bound_b) ? bound_b : bound_a;
                    max_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                v_next     = s_ext;
                cnt_next   = CNT_W'(1);
                tovf_next  = 1'b0;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (step_flags.at_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (v_reg < MEMO_LIM)
                begin
                    state_next = ST_MEMO;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_MEMO, ST_STEP:
            begin
                if ((state_reg == ST_MEMO) && (memo_rdata != '0))
                begin
                    cnt_next   = cnt_memo;
                    state_next = ST_FINISH;
                end
                else if (step_flags.ovf)
                begin
                    tovf_next  = 1'b1;
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    v_next     = step_value;
                    cnt_next   = cnt_inc;
                    state_next = ST_TEST;
                end
            end
            ST_FINISH:
            begin
                if (len_sat > max_reg)
                begin
                    max_next = len_sat;
                end
                if (s_reg == hi_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next     = s_reg + START_BITS'(1);
                    state_next = ST_START;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = max_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        hi_reg      <= hi_next;
        v_reg       <= v_next;
        cnt_reg     <= cnt_next;
        max_reg     <= max_next;
        ovf_reg     <= ovf_next;
        tovf_reg    <= tovf_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule
